// File: rtl/core/selt_pkg.sv
`default_nettype none
package selt_pkg;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_COMMIT  = 3'd1,
    CMD_ABORT   = 3'd2,
    CMD_ACQUIRE = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_e;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned TxnW = 16;
  localparam int unsigned ResW = 32;
  // Lock entry payload: {txn, resource, exclusive}.
  localparam int unsigned LockW = TxnW + ResW + 1;

endpackage
`default_nettype wire

// File: rtl/core/selt_ram.sv
`default_nettype none
module selt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/shared_exclusive_lock_table.sv
// Sequence: every request scans all transaction slots, then passes S_TXDONE. Commit,
// abort, acquire and release of an active id then sweep the lock memory, each entry in
// an S_LKREAD and an S_LKSCAN step; begin, an unknown id or an undefined command skip it.
// S_DECIDE then registers the result. One request is in flight at a time; the result is
// held in an output register until taken, and the next request is accepted once the
// block is back in S_IDLE. Reset clears all valid bits at once, so no clearing pass is
// needed, and the next id becomes one.
`default_nettype none
module shared_exclusive_lock_table
  import selt_pkg::*;
#(
  parameter int unsigned LOCK_ENTRIES = 64,
  parameter int unsigned TXN_SLOTS    = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [2:0]      command_i,
  input  wire logic [TxnW-1:0] txn_id_i,
  input  wire logic [ResW-1:0] resource_id_i,
  input  wire logic            want_exclusive_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 granted_o,
  output logic [1:0]           status_o,
  output logic [TxnW-1:0]      new_txn_id_o
);

  localparam int unsigned LkAw = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int unsigned TxAw = (TXN_SLOTS > 1) ? $clog2(TXN_SLOTS) : 1;
  localparam int unsigned LkCw = $clog2(LOCK_ENTRIES + 1);
  localparam int unsigned TxCw = $clog2(TXN_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TXSCAN, S_TXDONE, S_LKREAD, S_LKSCAN, S_DECIDE, S_OUT
  } state_e;

  state_e state_q;

  // Latched request.
  logic [2:0]      cmd_q;
  logic [TxnW-1:0] id_q;
  logic [ResW-1:0] res_q;
  logic            excl_q;

  // Transaction table: valid bits plus id registers.
  logic [TXN_SLOTS-1:0] tx_valid_q;
  logic [TxnW-1:0]      tx_id_q [TXN_SLOTS];
  logic [TxnW-1:0]      next_txn_q;

  // Lock table: valid bits in flops, payload in memory.
  logic [LOCK_ENTRIES-1:0] lk_valid_q;

  // Scan bookkeeping.
  logic [TxCw-1:0] tx_cnt_q;
  logic [LkCw-1:0] lk_cnt_q;
  logic [LkAw-1:0] rd_idx_q;
  logic            tx_hit_q, tx_free_q;
  logic [TxAw-1:0] tx_slot_q, tx_free_slot_q;
  logic            own_hit_q, own_excl_q, blk_x_q, blk_s_q, lk_free_q;
  logic [LkAw-1:0] own_idx_q, lk_free_idx_q;

  logic             ram_we;
  logic [LkAw-1:0]  ram_waddr;
  logic [LockW-1:0] ram_wdata, ram_rdata;
  logic [LkAw-1:0]  ram_raddr;

  selt_ram #(.Width(LockW), .Depth(1 << LkAw)) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fields of the entry read back from the registered read port.
  logic [TxnW-1:0] rd_txn;
  logic [ResW-1:0] rd_res;
  logic            rd_excl, rd_valid, rd_same_txn, rd_same_res;
  assign rd_txn      = ram_rdata[LockW-1 -: TxnW];
  assign rd_res      = ram_rdata[ResW:1];
  assign rd_excl     = ram_rdata[0];
  assign rd_valid    = lk_valid_q[rd_idx_q];
  assign rd_same_txn = (rd_txn == id_q);
  assign rd_same_res = (rd_res == res_q);
  assign ram_raddr   = lk_cnt_q[LkAw-1:0];

  // Transaction id compared in the shared slot comparator.
  logic [TxnW-1:0] tx_key;
  logic [TxAw-1:0] tx_idx;
  logic            tx_cmp;
  assign tx_key = (cmd_q == CMD_BEGIN) ? next_txn_q : id_q;
  assign tx_idx = tx_cnt_q[TxAw-1:0];
  assign tx_cmp = tx_valid_q[tx_idx] && (tx_id_q[tx_idx] == tx_key);

  // Memory write happens only on a new lock grant or an upgrade.
  logic do_new, do_upg;
  always_comb begin
    do_new = 1'b0;
    do_upg = 1'b0;
    if (state_q == S_DECIDE && cmd_q == CMD_ACQUIRE && tx_hit_q) begin
      if (own_hit_q) begin
        do_upg = !own_excl_q && excl_q && !blk_x_q;
      end else begin
        do_new = !(excl_q ? blk_x_q : blk_s_q) && lk_free_q;
      end
    end
  end
  assign ram_we    = do_new || do_upg;
  assign ram_waddr = do_upg ? own_idx_q : lk_free_idx_q;
  assign ram_wdata = {id_q, res_q, 1'b1 & (excl_q | do_upg)};

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer: slot scan, then lock table sweep for commands of an active id, then decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      tx_valid_q     <= '0;
      lk_valid_q     <= '0;
      next_txn_q     <= TxnW'(1);
      out_valid_o    <= 1'b0;
      tx_cnt_q       <= '0;
      lk_cnt_q       <= '0;
      cmd_q          <= '0;
      id_q           <= '0;
      res_q          <= '0;
      excl_q         <= 1'b0;
      tx_id_q        <= '{default: '0};
      rd_idx_q       <= '0;
      tx_hit_q       <= 1'b0;
      tx_free_q      <= 1'b0;
      tx_slot_q      <= '0;
      tx_free_slot_q <= '0;
      own_hit_q      <= 1'b0;
      own_excl_q     <= 1'b0;
      blk_x_q        <= 1'b0;
      blk_s_q        <= 1'b0;
      lk_free_q      <= 1'b0;
      own_idx_q      <= '0;
      lk_free_idx_q  <= '0;
      granted_o      <= 1'b0;
      status_o       <= ST_OK;
      new_txn_id_o   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= command_i;
            id_q      <= txn_id_i;
            res_q     <= resource_id_i;
            excl_q    <= want_exclusive_i;
            tx_cnt_q  <= '0;
            tx_hit_q  <= 1'b0;
            tx_free_q <= 1'b0;
            state_q   <= S_TXSCAN;
          end
        end
        S_TXSCAN: begin
          if (tx_cmp && !tx_hit_q) begin
            tx_hit_q  <= 1'b1;
            tx_slot_q <= tx_idx;
          end
          if (!tx_valid_q[tx_idx] && !tx_free_q) begin
            tx_free_q      <= 1'b1;
            tx_free_slot_q <= tx_idx;
          end
          if (tx_cnt_q == TxCw'(TXN_SLOTS - 1)) begin
            state_q <= S_TXDONE;
          end
          tx_cnt_q <= tx_cnt_q + 1'b1;
        end
        S_TXDONE: begin
          lk_cnt_q  <= '0;
          own_hit_q <= 1'b0;
          blk_x_q   <= 1'b0;
          blk_s_q   <= 1'b0;
          lk_free_q <= 1'b0;
          if (cmd_q == CMD_COMMIT || cmd_q == CMD_ABORT || cmd_q == CMD_ACQUIRE ||
              cmd_q == CMD_RELEASE) begin
            state_q <= tx_hit_q ? S_LKREAD : S_DECIDE;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_LKREAD: begin
          rd_idx_q <= lk_cnt_q[LkAw-1:0];
          lk_cnt_q <= lk_cnt_q + 1'b1;
          state_q  <= S_LKSCAN;
        end
        S_LKSCAN: begin
          if (rd_valid && rd_same_txn &&
              (cmd_q == CMD_COMMIT || cmd_q == CMD_ABORT)) begin
            lk_valid_q[rd_idx_q] <= 1'b0;
          end
          if (rd_valid && rd_same_txn && rd_same_res && !own_hit_q) begin
            own_hit_q  <= 1'b1;
            own_idx_q  <= rd_idx_q;
            own_excl_q <= rd_excl;
          end
          if (rd_valid && rd_same_res && !rd_same_txn) begin
            blk_x_q <= 1'b1;
            if (rd_excl) begin
              blk_s_q <= 1'b1;
            end
          end
          if (!rd_valid && !lk_free_q) begin
            lk_free_q     <= 1'b1;
            lk_free_idx_q <= rd_idx_q;
          end
          state_q <= (lk_cnt_q == LkCw'(LOCK_ENTRIES)) ? S_DECIDE : S_LKREAD;
        end
        S_DECIDE: begin
          granted_o    <= 1'b0;
          status_o     <= ST_OK;
          new_txn_id_o <= '0;
          priority if (cmd_q == CMD_BEGIN) begin
            if (tx_hit_q || tx_free_q) begin
              tx_valid_q[tx_hit_q ? tx_slot_q : tx_free_slot_q] <= 1'b1;
              tx_id_q[tx_hit_q ? tx_slot_q : tx_free_slot_q]    <= next_txn_q;
              new_txn_id_o <= next_txn_q;
              granted_o    <= 1'b1;
              next_txn_q   <= (next_txn_q == '1) ? TxnW'(1) : next_txn_q + 1'b1;
            end else begin
              status_o <= ST_FULL;
            end
          end else if (cmd_q == CMD_COMMIT || cmd_q == CMD_ABORT ||
                       cmd_q == CMD_ACQUIRE || cmd_q == CMD_RELEASE) begin
            if (!tx_hit_q) begin
              status_o <= ST_UNKNOWN;
            end else if (cmd_q == CMD_COMMIT || cmd_q == CMD_ABORT) begin
              tx_valid_q[tx_slot_q] <= 1'b0;
              granted_o <= 1'b1;
            end else if (cmd_q == CMD_RELEASE) begin
              if (own_hit_q) begin
                lk_valid_q[own_idx_q] <= 1'b0;
              end
              granted_o <= 1'b1;
            end else if (own_hit_q) begin
              if (own_excl_q || !excl_q || !blk_x_q) begin
                granted_o <= 1'b1;
              end else begin
                status_o <= ST_CONFLICT;
              end
            end else if (excl_q ? blk_x_q : blk_s_q) begin
              status_o <= ST_CONFLICT;
            end else if (!lk_free_q) begin
              status_o <= ST_FULL;
            end else begin
              lk_valid_q[lk_free_idx_q] <= 1'b1;
              granted_o <= 1'b1;
            end
          end else begin
            granted_o <= 1'b0;
          end
          out_valid_o <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/shared_exclusive_lock_table_tb.sv
`default_nettype none
module shared_exclusive_lock_table_tb;
  import selt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLocks = 64;
  localparam int unsigned NumSlots = 16;
  localparam logic [2:0] CmdUndefLo  = 3'd5;
  localparam logic [2:0] CmdUndefMid = 3'd6;
  localparam logic [2:0] CmdUndefHi  = 3'd7;

  typedef struct packed {
    logic [2:0]      command;
    logic [TxnW-1:0] txn_id;
    logic [ResW-1:0] resource_id;
    logic            want_exclusive;
  } lock_req_t;

  typedef struct packed {
    logic            granted;
    logic [1:0]      status;
    logic [TxnW-1:0] new_txn_id;
  } lock_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic [TxnW-1:0] txn_id_i = '0;
  logic [ResW-1:0] resource_id_i = '0;
  logic want_exclusive_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic granted_o;
  logic [1:0] status_o;
  logic [TxnW-1:0] new_txn_id_o;

  shared_exclusive_lock_table #(
    .LOCK_ENTRIES(NumLocks),
    .TXN_SLOTS   (NumSlots)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .txn_id_i        (txn_id_i),
    .resource_id_i   (resource_id_i),
    .want_exclusive_i(want_exclusive_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_o       (granted_o),
    .status_o        (status_o),
    .new_txn_id_o    (new_txn_id_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the lock manager state.
  logic            lk_valid [NumLocks];
  logic [TxnW-1:0] lk_txn   [NumLocks];
  logic [ResW-1:0] lk_res   [NumLocks];
  logic            lk_excl  [NumLocks];
  logic            tx_valid [NumSlots];
  logic [TxnW-1:0] tx_id    [NumSlots];
  logic [TxnW-1:0] next_id;

  lock_req_t pending_reqs[$];
  lock_rsp_t expected_rsps[$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int find_slot(logic [TxnW-1:0] id);
    for (int i = 0; i < NumSlots; i++) if (tx_valid[i] && tx_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_entry(logic [TxnW-1:0] id, logic [ResW-1:0] res);
    for (int i = 0; i < NumLocks; i++)
      if (lk_valid[i] && lk_txn[i] == id && lk_res[i] == res) return i;
    return -1;
  endfunction

  function automatic bit held_by_other(logic [TxnW-1:0] id, logic [ResW-1:0] res, bit excl);
    for (int i = 0; i < NumLocks; i++)
      if (lk_valid[i] && lk_res[i] == res && lk_txn[i] != id && (lk_excl[i] || excl))
        return 1'b1;
    return 1'b0;
  endfunction

  // Applies one request to the shadow state and returns the expected answer.
  function automatic lock_rsp_t apply_lock_request(lock_req_t r);
    lock_rsp_t a;
    int s;
    int e;
    a = '0;
    a.status = ST_OK;
    if (r.command == CMD_BEGIN) begin
      s = find_slot(next_id);
      if (s < 0)
        for (int i = 0; i < NumSlots; i++) if (!tx_valid[i]) begin s = i; break; end
      if (s < 0) begin
        a.status = ST_FULL;
      end else begin
        tx_valid[s] = 1'b1;
        tx_id[s] = next_id;
        a.new_txn_id = next_id;
        a.granted = 1'b1;
        next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
      end
    end else if (r.command <= CMD_RELEASE) begin
      s = find_slot(r.txn_id);
      if (s < 0) begin
        a.status = ST_UNKNOWN;
      end else if (r.command == CMD_COMMIT || r.command == CMD_ABORT) begin
        for (int i = 0; i < NumLocks; i++) if (lk_txn[i] == r.txn_id) lk_valid[i] = 1'b0;
        tx_valid[s] = 1'b0;
        a.granted = 1'b1;
      end else if (r.command == CMD_RELEASE) begin
        e = find_entry(r.txn_id, r.resource_id);
        if (e >= 0) lk_valid[e] = 1'b0;
        a.granted = 1'b1;
      end else begin
        e = find_entry(r.txn_id, r.resource_id);
        if (e >= 0) begin
          if (lk_excl[e] || !r.want_exclusive) a.granted = 1'b1;
          else if (held_by_other(r.txn_id, r.resource_id, 1'b1)) a.status = ST_CONFLICT;
          else begin
            lk_excl[e] = 1'b1;
            a.granted = 1'b1;
          end
        end else if (held_by_other(r.txn_id, r.resource_id, r.want_exclusive)) begin
          a.status = ST_CONFLICT;
        end else begin
          for (int i = 0; i < NumLocks; i++) if (!lk_valid[i]) begin e = i; break; end
          if (e < 0) a.status = ST_FULL;
          else begin
            lk_valid[e] = 1'b1;
            lk_txn[e] = r.txn_id;
            lk_res[e] = r.resource_id;
            lk_excl[e] = r.want_exclusive;
            a.granted = 1'b1;
          end
        end
      end
    end
    return a;
  endfunction

  function automatic lock_req_t mk_req(logic [2:0] c, logic [TxnW-1:0] t,
                                       logic [ResW-1:0] res, bit x);
    lock_req_t r;
    r.command = c;
    r.txn_id = t;
    r.resource_id = res;
    r.want_exclusive = x;
    return r;
  endfunction

  // Appends one request to the pending queue.
  function automatic void add_req(lock_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Picks a transaction id that is most likely active.
  function automatic logic [TxnW-1:0] pick_txn();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return TxnW'($urandom);
    if (k == 1) return '0;
    if (next_id > 1 && k < 10) return next_id - TxnW'($urandom_range(1, 8));
    return TxnW'($urandom_range(1, 40));
  endfunction

  // Resources come from a small pool so that conflicts happen often.
  function automatic logic [ResW-1:0] pick_res();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return $urandom;
    if (k == 1) return 32'hFFFF_FFFF;
    if (k == 2) return '0;
    return ResW'($urandom_range(1, 12));
  endfunction

  // Driver: presents pending requests with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          command_i <= pending_reqs[0].command;
          txn_id_i <= pending_reqs[0].txn_id;
          resource_id_i <= pending_reqs[0].resource_id;
          want_exclusive_i <= pending_reqs[0].want_exclusive;
          void'(pending_reqs.pop_front());
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted requests, checks accepted answers.
  always @(posedge clk_i) begin
    lock_req_t r;
    lock_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r = mk_req(command_i, txn_id_i, resource_id_i, want_exclusive_i);
        expected_rsps.insert(expected_rsps.size(), apply_lock_request(r));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected answer granted=%0d status=%0d", granted_o, status_o);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (granted_o !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, granted_o);
            mismatches++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (new_txn_id_o !== want.new_txn_id) begin
            $error("new_txn_id: expected %0d, got %0d", want.new_txn_id, new_txn_id_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [TxnW-1:0] t;
    for (int i = 0; i < NumLocks; i++) begin
      lk_valid[i] = 1'b0; lk_txn[i] = '0; lk_res[i] = '0; lk_excl[i] = 1'b0;
    end
    for (int i = 0; i < NumSlots; i++) begin
      tx_valid[i] = 1'b0; tx_id[i] = '0;
    end
    next_id = 16'd1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: begins, shared/exclusive mixes, upgrade, conflicts, unknown ids, undefined commands, commits, aborts.
    add_req(mk_req(CMD_ACQUIRE, 16'd0, 32'd5, 1'b0));
    add_req(mk_req(CMD_BEGIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    add_req(mk_req(CMD_BEGIN, 16'd0, 32'd0, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd1, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd2, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd1, 32'hFFFF_FFFF, 1'b1));
    add_req(mk_req(CMD_RELEASE, 16'd2, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd1, 32'hFFFF_FFFF, 1'b1));
    add_req(mk_req(CMD_ACQUIRE, 16'd1, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd2, 32'hFFFF_FFFF, 1'b0));
    add_req(mk_req(CMD_ACQUIRE, 16'd2, 32'd0, 1'b1));
    add_req(mk_req(CMD_ACQUIRE, 16'd1, 32'd0, 1'b0));
    add_req(mk_req(CMD_RELEASE, 16'd1, 32'd77, 1'b1));
    add_req(mk_req(CMD_RELEASE, 16'hFFFF, 32'd0, 1'b0));
    add_req(mk_req(CmdUndefLo, 16'd1, 32'd0, 1'b1));
    add_req(mk_req(CmdUndefMid, 16'd2, 32'd0, 1'b1));
    add_req(mk_req(CmdUndefHi, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    add_req(mk_req(CMD_COMMIT, 16'd1, 32'd0, 1'b0));
    add_req(mk_req(CMD_ABORT, 16'd2, 32'd0, 1'b0));
    add_req(mk_req(CMD_ABORT, 16'd2, 32'd0, 1'b0));
    // Fill the transaction table to overflow.
    for (int i = 0; i < NumSlots + 1; i++)
      add_req(mk_req(CMD_BEGIN, '0, '0, 1'b0));
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_rsps.size() == 0);

    // Fill the lock table with one transaction on distinct resources.
    t = next_id - 16'd1;
    for (int i = 0; i < NumLocks + 2; i++)
      add_req(mk_req(CMD_ACQUIRE, t, 32'h1000 + i, i[0]));
    add_req(mk_req(CMD_COMMIT, t, '0, 1'b0));
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_rsps.size() == 0);

    // Random traffic, mostly acquire and release on live ids.
    for (int n = 0; n < 1600; n++) begin
      int k;
      logic [2:0] c;
      if (n == 1500) begin
        wait (pending_reqs.size() == 0);
        calm = 1'b1;
      end
      k = $urandom_range(0, 99);
      if (k < 10) c = CMD_BEGIN;
      else if (k < 15) c = CMD_COMMIT;
      else if (k < 19) c = CMD_ABORT;
      else if (k < 70) c = CMD_ACQUIRE;
      else if (k < 97) c = CMD_RELEASE;
      else c = 3'($urandom_range(CmdUndefLo, CmdUndefHi));
      add_req(mk_req(c, pick_txn(), pick_res(), 1'($urandom_range(0, 1))));
      // Keep the queue short so prediction tracks the shadow state closely.
      wait (pending_reqs.size() < 4);
    end

    // Wrap the id counter by steering next_id through many begins is too slow;
    // the allocator wrap is reached only through long runs, so skip it here.
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_rsps.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("** shared_exclusive_lock_table: PASSED **");
    end else begin
      $display("** shared_exclusive_lock_table: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("** shared_exclusive_lock_table: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
